[hw/rtl/triangle_normal_tangent_unit_macros.svh]
// ----------------------------------------------------------------------------
// Triangle normal/tangent unit assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_NORMAL_TANGENT_UNIT_MACROS_SVH
`define TRIANGLE_NORMAL_TANGENT_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TNT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define TNT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define TNT_ASSERT(lbl, clk, rstn, prop, msg)
`define TNT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[hw/rtl/tnt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle normal/tangent package
// Shared types, widths and codes.
// ----------------------------------------------------------------------------
package tnt_pkg;

  localparam int unsigned POS_W     = 24;
  localparam int unsigned TEX_W     = 16;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned IDX_CMP_W = 17;
  localparam int unsigned DIV_NW    = 58;
  localparam int unsigned DIV_DW    = 34;
  localparam int unsigned SQ_W      = 64;
  localparam int unsigned ROOT_W    = 32;

  localparam logic ACT_VERTEX   = 1'b0;
  localparam logic ACT_TRIANGLE = 1'b1;

  // multiply schedule
  localparam logic [4:0] LAST_PAIR_STEP = 5'd13;
  localparam logic [4:0] FIRST_SQ_STEP  = 5'd14;
  localparam logic [4:0] LAST_SQ_STEP   = 5'd16;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_READ     = 10'b0000000010,
    S_MUL      = 10'b0000000100,
    S_ACC      = 10'b0000001000,
    S_SHIFT    = 10'b0000010000,
    S_SQ_GO    = 10'b0000100000,
    S_SQ_WAIT  = 10'b0001000000,
    S_DIV_GO   = 10'b0010000000,
    S_DIV_WAIT = 10'b0100000000,
    S_FIN      = 10'b1000000000
  } state_e;

endpackage

[hw/rtl/tnt_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle normal/tangent input channel
// Vertex write or triangle word with valid/ready.
// ----------------------------------------------------------------------------
interface tnt_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [9:0]         vertex_index;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] pos_z;
  logic signed [15:0] tex_u;
  logic signed [15:0] tex_v;
  logic [9:0]         corner_a;
  logic [9:0]         corner_b;
  logic [9:0]         corner_c;
  logic               want_tangent;

  modport source (
    output valid, action, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
           corner_a, corner_b, corner_c, want_tangent,
    input  ready
  );
  modport sink (
    input  valid, action, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
           corner_a, corner_b, corner_c, want_tangent,
    output ready
  );
endinterface

[hw/rtl/tnt_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle normal/tangent result channel
// Normal, tangent and flags with valid/ready.
// ----------------------------------------------------------------------------
interface tnt_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [31:0] tangent_x;
  logic signed [31:0] tangent_y;
  logic signed [31:0] tangent_z;
  logic               tangent_valid;
  logic               flat_triangle;
  logic               uv_degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z,
           tangent_valid, flat_triangle, uv_degenerate,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z,
           tangent_valid, flat_triangle, uv_degenerate,
    output ready
  );
endinterface

[hw/rtl/tnt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tnt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[hw/rtl/tnt_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle normal/tangent divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tnt_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tnt_pkg::DIV_NW-1:0]    num_i,
  input  logic [tnt_pkg::DIV_DW-1:0]    den_i,
  output logic [tnt_pkg::DIV_NW-1:0]    quot_o,
  output tnt_pkg::unit_stat_t           stat_o
);
  localparam int unsigned NW = tnt_pkg::DIV_NW;
  localparam int unsigned DW = tnt_pkg::DIV_DW;
  localparam int unsigned CW = $clog2(NW);

  logic [NW-1:0] nq_q;
  logic [DW-1:0] den_q;
  logic [DW-1:0] rem_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW:0]   trial;
  logic          take;

  assign trial = {rem_q, nq_q[NW-1]};
  assign take  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      nq_q  <= {nq_q[NW-2:0], take};
    end
  end

  assign quot_o      = nq_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
endmodule

[hw/rtl/tnt_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle normal/tangent square root
// Floor integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module tnt_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tnt_pkg::SQ_W-1:0]      x_i,
  output logic [tnt_pkg::ROOT_W-1:0]    root_o,
  output tnt_pkg::unit_stat_t           stat_o
);
  localparam int unsigned W = tnt_pkg::SQ_W;

  logic [W-1:0] x_q;
  logic [W-1:0] r_q;
  logic [W-1:0] bit_q;
  logic         busy_q;
  logic         done_q;
  logic [W-1:0] trial;

  assign trial = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (bit_q[W-1:2] == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      r_q   <= '0;
      bit_q <= W'(1) << (W - 2);
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_q <= x_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign root_o      = r_q[tnt_pkg::ROOT_W-1:0];
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
endmodule

[hw/rtl/triangle_normal_tangent_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal and texture tangent unit
// Vertex store in RAM; per triangle a unit face normal and a UV tangent.
// ----------------------------------------------------------------------------
// A triangle reads its three corners from the vertex RAM, then runs every
// product through one shared 32x32 multiplier, a shift-normalise loop, a
// 32-step square root and a 58-step divider that serves the three normal and
// three tangent components in turn; the divider sets most of a triangle's run
// time. The next word is taken once the previous triangle's result sits in the
// output register.
`include "triangle_normal_tangent_unit_macros.svh"
module triangle_normal_tangent_unit #(
  parameter int unsigned VERTEX_COUNT = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  tnt_in_if.sink    in_i,
  tnt_out_if.source res_o
);
  localparam int unsigned AddrW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int unsigned CmpW  = tnt_pkg::IDX_CMP_W;
  localparam int unsigned PosWW = 3 * tnt_pkg::POS_W;
  localparam int unsigned TexWW = 2 * tnt_pkg::TEX_W;

  tnt_pkg::state_e state_q, state_d;

  logic                uv_en_q;
  logic [9:0]          corner_q [3];
  logic [1:0]          rd_cnt_q;
  logic                rd_ok_q;
  logic                tvalid_q;
  logic signed [23:0]  pos_q [3][3];
  logic signed [15:0]  tex_q [3][2];
  logic [4:0]          ms_q;
  logic signed [63:0]  prod_q;
  logic signed [63:0]  acc_q;
  logic signed [51:0]  val_q [7];
  logic [50:0]         m_q [3];
  logic [31:0]         len_q;
  logic [2:0]          di_q;
  logic signed [15:0]  nrm_q [3];
  logic signed [31:0]  tan_q [3];
  logic                out_valid_q;
  logic signed [15:0]  o_nrm_q [3];
  logic signed [31:0]  o_tan_q [3];
  logic                o_tv_q;
  logic                o_flat_q;
  logic                o_degen_q;

  // RAM ports
  logic                pos_we;
  logic [AddrW-1:0]    waddr;
  logic [AddrW-1:0]    raddr;
  logic [9:0]          rd_idx;
  logic [PosWW-1:0]    pos_rdata;
  logic [TexWW-1:0]    tex_rdata;

  logic                in_acc;
  logic                out_load;
  logic                wr_in_range;
  logic                rd_in_range;

  logic signed [24:0]  e1 [3];
  logic signed [24:0]  e2 [3];
  logic signed [24:0]  dp1 [3];
  logic signed [24:0]  dp2 [3];
  logic signed [16:0]  du1, dv1, du2, dv2;
  logic signed [31:0]  op_a, op_b;

  logic                flat;
  logic                any_hi;
  logic                tan_need;
  logic signed [51:0]  div_val;
  logic [51:0]         div_mag;
  logic [51:0]         det_mag;
  logic [29:0]         mk;
  logic [tnt_pkg::DIV_NW-1:0] div_num;
  logic [tnt_pkg::DIV_DW-1:0] div_den;
  logic [tnt_pkg::DIV_NW-1:0] quot;
  logic                div_start;
  logic                sq_start;
  logic [31:0]         root;
  tnt_pkg::unit_stat_t div_stat;
  tnt_pkg::unit_stat_t sq_stat;
  logic [1:0]          slot;
  logic [1:0]          tk;

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == tnt_pkg::S_IDLE);
  assign out_load = (state_q == tnt_pkg::S_FIN) && (!out_valid_q || res_o.ready);

  assign wr_in_range = ({{(CmpW - 10){1'b0}}, in_i.vertex_index} < CmpW'(VERTEX_COUNT));
  assign pos_we = in_acc && (in_i.action == tnt_pkg::ACT_VERTEX) && wr_in_range;
  assign waddr  = AddrW'(in_i.vertex_index);

  always_comb begin
    case (rd_cnt_q)
      2'd0:    rd_idx = corner_q[0];
      2'd1:    rd_idx = corner_q[1];
      default: rd_idx = corner_q[2];
    endcase
  end
  assign raddr       = AddrW'(rd_idx);
  assign rd_in_range = ({{(CmpW - 10){1'b0}}, rd_idx} < CmpW'(VERTEX_COUNT));
  assign slot        = rd_cnt_q - 2'd1;

  tnt_ram #(.WIDTH(PosWW), .DEPTH(VERTEX_COUNT)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (waddr),
    .wdata_i ({in_i.pos_x, in_i.pos_y, in_i.pos_z}),
    .raddr_i (raddr),
    .rdata_o (pos_rdata)
  );

  tnt_ram #(.WIDTH(TexWW), .DEPTH(VERTEX_COUNT)) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (waddr),
    .wdata_i ({in_i.tex_u, in_i.tex_v}),
    .raddr_i (raddr),
    .rdata_o (tex_rdata)
  );

  // edges and UV deltas
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k]  = 25'(pos_q[0][k]) - 25'(pos_q[1][k]);
      e2[k]  = 25'(pos_q[0][k]) - 25'(pos_q[2][k]);
      dp1[k] = 25'(pos_q[1][k]) - 25'(pos_q[0][k]);
      dp2[k] = 25'(pos_q[2][k]) - 25'(pos_q[0][k]);
    end
    du1 = 17'(tex_q[1][0]) - 17'(tex_q[0][0]);
    dv1 = 17'(tex_q[1][1]) - 17'(tex_q[0][1]);
    du2 = 17'(tex_q[2][0]) - 17'(tex_q[0][0]);
    dv2 = 17'(tex_q[2][1]) - 17'(tex_q[0][1]);
  end

  // product schedule: pairs give cross x/y/z, det, num x/y/z; then squares
  always_comb begin
    case (ms_q)
      5'd0:    begin op_a = 32'(e1[1]);  op_b = 32'(e2[2]); end
      5'd1:    begin op_a = 32'(e1[2]);  op_b = 32'(e2[1]); end
      5'd2:    begin op_a = 32'(e1[2]);  op_b = 32'(e2[0]); end
      5'd3:    begin op_a = 32'(e1[0]);  op_b = 32'(e2[2]); end
      5'd4:    begin op_a = 32'(e1[0]);  op_b = 32'(e2[1]); end
      5'd5:    begin op_a = 32'(e1[1]);  op_b = 32'(e2[0]); end
      5'd6:    begin op_a = 32'(du1);    op_b = 32'(dv2);   end
      5'd7:    begin op_a = 32'(dv1);    op_b = 32'(du2);   end
      5'd8:    begin op_a = 32'(dp1[0]); op_b = 32'(dv2);   end
      5'd9:    begin op_a = 32'(dp2[0]); op_b = 32'(dv1);   end
      5'd10:   begin op_a = 32'(dp1[1]); op_b = 32'(dv2);   end
      5'd11:   begin op_a = 32'(dp2[1]); op_b = 32'(dv1);   end
      5'd12:   begin op_a = 32'(dp1[2]); op_b = 32'(dv2);   end
      5'd13:   begin op_a = 32'(dp2[2]); op_b = 32'(dv1);   end
      5'd14:   begin op_a = {2'b00, m_q[0][29:0]}; op_b = {2'b00, m_q[0][29:0]}; end
      5'd15:   begin op_a = {2'b00, m_q[1][29:0]}; op_b = {2'b00, m_q[1][29:0]}; end
      5'd16:   begin op_a = {2'b00, m_q[2][29:0]}; op_b = {2'b00, m_q[2][29:0]}; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign flat     = (val_q[0] == '0) && (val_q[1] == '0) && (val_q[2] == '0);
  assign any_hi   = (|m_q[0][50:30]) || (|m_q[1][50:30]) || (|m_q[2][50:30]);
  assign tan_need = tvalid_q && (val_q[3] != '0);

  // divider operands: normals use L, tangents use |det|
  assign div_val = (di_q < 3'd3) ? val_q[di_q] : val_q[di_q + 3'd1];
  assign div_mag = div_val[51] ? 52'(-div_val) : div_val;
  assign det_mag = val_q[3][51] ? 52'(-val_q[3]) : val_q[3];
  assign mk      = m_q[di_q[1:0]][29:0];
  always_comb begin
    if (di_q < 3'd3) begin
      div_num = (tnt_pkg::DIV_NW'(mk) << 14) + tnt_pkg::DIV_NW'(len_q >> 1);
      div_den = tnt_pkg::DIV_DW'(len_q);
    end else begin
      div_num = (tnt_pkg::DIV_NW'(div_mag[41:0]) << 14)
              + tnt_pkg::DIV_NW'(det_mag[33:1]);
      div_den = det_mag[33:0];
    end
  end

  assign div_start = (state_q == tnt_pkg::S_DIV_GO);
  assign sq_start  = (state_q == tnt_pkg::S_SQ_GO);
  assign tk        = 2'(di_q - 3'd3);

  tnt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (quot),
    .stat_o  (div_stat)
  );

  tnt_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .x_i     (acc_q),
    .root_o  (root),
    .stat_o  (sq_stat)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tnt_pkg::S_IDLE: begin
        if (in_acc && (in_i.action == tnt_pkg::ACT_TRIANGLE)) state_d = tnt_pkg::S_READ;
      end
      tnt_pkg::S_READ: begin
        if (rd_cnt_q == 2'd3) state_d = tnt_pkg::S_MUL;
      end
      tnt_pkg::S_MUL: state_d = tnt_pkg::S_ACC;
      tnt_pkg::S_ACC: begin
        if (ms_q == tnt_pkg::LAST_PAIR_STEP) state_d = tnt_pkg::S_SHIFT;
        else if (ms_q == tnt_pkg::LAST_SQ_STEP) state_d = tnt_pkg::S_SQ_GO;
        else state_d = tnt_pkg::S_MUL;
      end
      tnt_pkg::S_SHIFT: begin
        if (flat) state_d = tan_need ? tnt_pkg::S_DIV_GO : tnt_pkg::S_FIN;
        else if (!any_hi) state_d = tnt_pkg::S_MUL;
      end
      tnt_pkg::S_SQ_GO: state_d = tnt_pkg::S_SQ_WAIT;
      tnt_pkg::S_SQ_WAIT: begin
        if (sq_stat.done) state_d = tnt_pkg::S_DIV_GO;
      end
      tnt_pkg::S_DIV_GO: state_d = tnt_pkg::S_DIV_WAIT;
      tnt_pkg::S_DIV_WAIT: begin
        if (div_stat.done) begin
          if (di_q == 3'd5) state_d = tnt_pkg::S_FIN;
          else if ((di_q == 3'd2) && !tan_need) state_d = tnt_pkg::S_FIN;
          else state_d = tnt_pkg::S_DIV_GO;
        end
      end
      tnt_pkg::S_FIN: begin
        if (out_load) state_d = tnt_pkg::S_IDLE;
      end
      default: state_d = tnt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tnt_pkg::S_IDLE;
      uv_en_q     <= 1'b0;
      rd_cnt_q    <= '0;
      ms_q        <= '0;
      di_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) uv_en_q <= cfg_wdata_i;
      if (state_q == tnt_pkg::S_IDLE) begin
        rd_cnt_q <= '0;
        ms_q     <= '0;
      end
      if (state_q == tnt_pkg::S_READ) rd_cnt_q <= rd_cnt_q + 2'd1;
      if ((state_q == tnt_pkg::S_ACC) && (ms_q != tnt_pkg::LAST_PAIR_STEP)) begin
        ms_q <= ms_q + 5'd1;
      end
      if ((state_q == tnt_pkg::S_SHIFT) && !flat && !any_hi) ms_q <= tnt_pkg::FIRST_SQ_STEP;
      if ((state_q == tnt_pkg::S_SHIFT) && flat) di_q <= 3'd3;
      if ((state_q == tnt_pkg::S_SQ_WAIT) && sq_stat.done) di_q <= '0;
      if ((state_q == tnt_pkg::S_DIV_WAIT) && div_stat.done) di_q <= di_q + 3'd1;
      if (out_load) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rd_ok_q <= rd_in_range;
    if (in_acc && (in_i.action == tnt_pkg::ACT_TRIANGLE)) begin
      corner_q[0] <= in_i.corner_a;
      corner_q[1] <= in_i.corner_b;
      corner_q[2] <= in_i.corner_c;
      tvalid_q    <= in_i.want_tangent && uv_en_q;
      for (int k = 0; k < 3; k++) begin
        nrm_q[k] <= '0;
        tan_q[k] <= '0;
      end
    end
    // read data lands in the cycle after its address
    if ((state_q == tnt_pkg::S_READ) && (rd_cnt_q != 2'd0)) begin
      pos_q[slot][0] <= rd_ok_q ? pos_rdata[71:48] : '0;
      pos_q[slot][1] <= rd_ok_q ? pos_rdata[47:24] : '0;
      pos_q[slot][2] <= rd_ok_q ? pos_rdata[23:0]  : '0;
      tex_q[slot][0] <= rd_ok_q ? tex_rdata[31:16] : '0;
      tex_q[slot][1] <= rd_ok_q ? tex_rdata[15:0]  : '0;
    end
    if (state_q == tnt_pkg::S_MUL) prod_q <= op_a * op_b;
    if (state_q == tnt_pkg::S_ACC) begin
      if (ms_q <= tnt_pkg::LAST_PAIR_STEP) begin
        if (!ms_q[0]) acc_q <= prod_q;
        else val_q[ms_q[3:1]] <= 52'(acc_q - prod_q);
      end else begin
        acc_q <= ((ms_q == tnt_pkg::FIRST_SQ_STEP) ? 64'sd0 : acc_q) + prod_q;
      end
      if (ms_q == tnt_pkg::LAST_PAIR_STEP) begin
        for (int k = 0; k < 3; k++) begin
          m_q[k] <= val_q[k][51] ? 51'(-val_q[k]) : 51'(val_q[k]);
        end
      end
    end
    if ((state_q == tnt_pkg::S_SHIFT) && any_hi) begin
      for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
    end
    if ((state_q == tnt_pkg::S_SQ_WAIT) && sq_stat.done) len_q <= root;
    if ((state_q == tnt_pkg::S_DIV_WAIT) && div_stat.done) begin
      if (di_q < 3'd3) begin
        nrm_q[di_q[1:0]] <= div_val[51] ? 16'(-quot[15:0]) : quot[15:0];
      end else if (quot == '0) begin
        tan_q[tk] <= '0;
      end else if (div_val[51] != val_q[3][51]) begin
        tan_q[tk] <= (quot > tnt_pkg::DIV_NW'(64'd2147483648)) ? 32'sh8000_0000
                   : 32'(32'd0 - quot[31:0]);
      end else begin
        tan_q[tk] <= (quot > tnt_pkg::DIV_NW'(64'd2147483647)) ? 32'sh7fff_ffff
                   : quot[31:0];
      end
    end
    if (out_load) begin
      for (int k = 0; k < 3; k++) begin
        o_nrm_q[k] <= nrm_q[k];
        o_tan_q[k] <= tan_q[k];
      end
      o_tv_q    <= tvalid_q;
      o_flat_q  <= flat;
      o_degen_q <= tvalid_q && (val_q[3] == '0);
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.normal_x      = o_nrm_q[0];
  assign res_o.normal_y      = o_nrm_q[1];
  assign res_o.normal_z      = o_nrm_q[2];
  assign res_o.tangent_x     = o_tan_q[0];
  assign res_o.tangent_y     = o_tan_q[1];
  assign res_o.tangent_z     = o_tan_q[2];
  assign res_o.tangent_valid = o_tv_q;
  assign res_o.flat_triangle = o_flat_q;
  assign res_o.uv_degenerate = o_degen_q;

  `TNT_ASSERT(a_div_start_idle, clk_i, rst_ni, div_start |-> !div_stat.busy,
              "divider restarted while busy")
  `TNT_ASSERT(a_sqrt_start_idle, clk_i, rst_ni, sq_start |-> !sq_stat.busy,
              "square root restarted while busy")
  `TNT_NEVER(a_no_tan_zero, clk_i, rst_ni,
             res_o.valid && !res_o.tangent_valid && (res_o.tangent_x != 0 ||
             res_o.tangent_y != 0 || res_o.tangent_z != 0 || res_o.uv_degenerate),
             "tangent set without request")
  `TNT_NEVER(a_flat_zero, clk_i, rst_ni,
             res_o.valid && res_o.flat_triangle && (res_o.normal_x != 0 ||
             res_o.normal_y != 0 || res_o.normal_z != 0),
             "flat triangle with nonzero normal")
  `TNT_NEVER(a_degen_zero, clk_i, rst_ni,
             res_o.valid && res_o.uv_degenerate && (res_o.tangent_x != 0 ||
             res_o.tangent_y != 0 || res_o.tangent_z != 0),
             "degenerate UV with nonzero tangent")
endmodule

[tb/triangle_normal_tangent_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle normal/tangent unit testbench
// Writes vertices and sends triangles through the input channel, predicts the
// face normal and tangent of each triangle, and checks every result word in
// order against the prediction, under random idling on both channels.
// ----------------------------------------------------------------------------
module triangle_normal_tangent_unit_tb;

  localparam int unsigned NUM_VERTS   = 1024;
  localparam int unsigned WDOG_LIMIT  = 30000;
  localparam int unsigned SETTLE_CYC  = 600;
  localparam int unsigned HOLD_CYC    = 3000;
  localparam int unsigned PHASE_WORDS = 245;

  typedef struct packed {
    logic               action;
    logic [9:0]         vertex_index;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
    logic [9:0]         corner_a;
    logic [9:0]         corner_b;
    logic [9:0]         corner_c;
    logic               want_tangent;
  } word_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic               tangent_valid;
    logic               flat_triangle;
    logic               uv_degenerate;
  } face_t;

  class face_scoreboard;
    longint vpos[NUM_VERTS][3];
    longint vtex[NUM_VERTS][2];
    bit     uv_en;
    face_t  pending_faces[$];
    int     mismatches;
    int     faces_seen;

    // round(n * 2^14 / d), half away from zero
    function longint unsigned div_round14(longint unsigned n, longint unsigned d);
      return ((n << 14) + (d >> 1)) / d;
    endfunction

    function face_t predict_face(word_t w);
      longint          pa[3], pb[3], pc[3], ta[2], tb[2], tc[2];
      longint          e1[3], e2[3], cr[3];
      longint          du1, dv1, du2, dv2, det, num;
      longint unsigned m[3], mx, sum, len, rem, bitv, q, dm;
      longint          t;
      int              s;
      face_t           f;
      f = '0;
      for (int k = 0; k < 3; k++) begin
        pa[k] = vpos[w.corner_a][k];
        pb[k] = vpos[w.corner_b][k];
        pc[k] = vpos[w.corner_c][k];
      end
      for (int k = 0; k < 2; k++) begin
        ta[k] = vtex[w.corner_a][k];
        tb[k] = vtex[w.corner_b][k];
        tc[k] = vtex[w.corner_c][k];
      end
      for (int k = 0; k < 3; k++) begin
        e1[k] = pa[k] - pb[k];
        e2[k] = pa[k] - pc[k];
      end
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      f.flat_triangle = (cr[0] == 0) && (cr[1] == 0) && (cr[2] == 0);
      if (!f.flat_triangle) begin
        for (int k = 0; k < 3; k++) m[k] = (cr[k] < 0) ? -cr[k] : cr[k];
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        s = 0;
        while ((mx >> s) >= (64'd1 << 30)) s++;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
          m[k] = m[k] >> s;
          sum += m[k] * m[k];
        end
        // bitwise integer square root
        rem = sum;
        len = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
          if (rem >= len + bitv) begin
            rem = rem - (len + bitv);
            len = (len >> 1) + bitv;
          end else begin
            len = len >> 1;
          end
          bitv = bitv >> 2;
        end
        t = div_round14(m[0], len);
        f.normal_x = 16'((cr[0] < 0) ? -t : t);
        t = div_round14(m[1], len);
        f.normal_y = 16'((cr[1] < 0) ? -t : t);
        t = div_round14(m[2], len);
        f.normal_z = 16'((cr[2] < 0) ? -t : t);
      end
      f.tangent_valid = w.want_tangent && uv_en;
      if (f.tangent_valid) begin
        du1 = tb[0] - ta[0];
        dv1 = tb[1] - ta[1];
        du2 = tc[0] - ta[0];
        dv2 = tc[1] - ta[1];
        det = du1 * dv2 - dv1 * du2;
        if (det == 0) begin
          f.uv_degenerate = 1'b1;
        end else begin
          dm = (det < 0) ? -det : det;
          for (int k = 0; k < 3; k++) begin
            num = (pb[k] - pa[k]) * dv2 - (pc[k] - pa[k]) * dv1;
            q = div_round14((num < 0) ? -num : num, dm);
            if (q == 0) t = 0;
            else if ((num < 0) != (det < 0)) t = (q > 64'd2147483648) ? -64'sd2147483648 : -q;
            else t = (q > 64'd2147483647) ? 64'sd2147483647 : q;
            case (k)
              0: f.tangent_x = 32'(t);
              1: f.tangent_y = 32'(t);
              default: f.tangent_z = 32'(t);
            endcase
          end
        end
      end
      return f;
    endfunction

    function void note_word(word_t w);
      if (w.action == tnt_pkg::ACT_VERTEX) begin
        vpos[w.vertex_index][0] = w.pos_x;
        vpos[w.vertex_index][1] = w.pos_y;
        vpos[w.vertex_index][2] = w.pos_z;
        vtex[w.vertex_index][0] = w.tex_u;
        vtex[w.vertex_index][1] = w.tex_v;
      end else begin
        pending_faces.push_back(predict_face(w));
      end
    endfunction

    function void check_face(face_t got);
      face_t exp_f;
      faces_seen++;
      if (pending_faces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
        return;
      end
      exp_f = pending_faces.pop_front();
      if (got !== exp_f) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d mismatch", faces_seen);
          $display("  exp n=(%0d,%0d,%0d) t=(%0d,%0d,%0d) tv=%b flat=%b degen=%b",
                   exp_f.normal_x, exp_f.normal_y, exp_f.normal_z, exp_f.tangent_x,
                   exp_f.tangent_y, exp_f.tangent_z, exp_f.tangent_valid,
                   exp_f.flat_triangle, exp_f.uv_degenerate);
          $display("  got n=(%0d,%0d,%0d) t=(%0d,%0d,%0d) tv=%b flat=%b degen=%b",
                   got.normal_x, got.normal_y, got.normal_z, got.tangent_x,
                   got.tangent_y, got.tangent_z, got.tangent_valid,
                   got.flat_triangle, got.uv_degenerate);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  tnt_in_if  in_if ();
  tnt_out_if res_if ();

  triangle_normal_tangent_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .res_o       (res_if)
  );

  face_scoreboard sb;
  bit             calm;        // no idling on either side
  bit             hold_req;    // ask the receiver for one long hold-off
  bit             written[NUM_VERTS];
  int             written_list[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic push_word(word_t w);
    in_if.valid        <= 1'b1;
    in_if.action       <= w.action;
    in_if.vertex_index <= w.vertex_index;
    in_if.pos_x        <= w.pos_x;
    in_if.pos_y        <= w.pos_y;
    in_if.pos_z        <= w.pos_z;
    in_if.tex_u        <= w.tex_u;
    in_if.tex_v        <= w.tex_v;
    in_if.corner_a     <= w.corner_a;
    in_if.corner_b     <= w.corner_b;
    in_if.corner_c     <= w.corner_c;
    in_if.want_tangent <= w.want_tangent;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_word(w);
    if (w.action == tnt_pkg::ACT_VERTEX && !written[w.vertex_index]) begin
      written[w.vertex_index] = 1'b1;
      written_list.push_back(w.vertex_index);
    end
    if (!calm && $urandom_range(99) < 10) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic word_t noise_word();
    logic [191:0] r;
    r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return r[$bits(word_t)-1:0];
  endfunction

  task automatic put_vertex(int idx, int x, int y, int z, int u, int v);
    word_t w;
    w = noise_word();
    w.action = tnt_pkg::ACT_VERTEX;
    w.vertex_index = 10'(idx);
    w.pos_x = 24'(x); w.pos_y = 24'(y); w.pos_z = 24'(z);
    w.tex_u = 16'(u); w.tex_v = 16'(v);
    push_word(w);
  endtask

  task automatic put_triangle(int a, int b, int c, bit want);
    word_t w;
    w = noise_word();
    w.action = tnt_pkg::ACT_TRIANGLE;
    w.corner_a = 10'(a); w.corner_b = 10'(b); w.corner_c = 10'(c);
    w.want_tangent = want;
    push_word(w);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.pending_faces.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_uv(bit en);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.uv_en = en;
  endtask

  task automatic random_phase(int words);
    word_t w;
    int    scale;
    for (int i = 0; i < words; i++) begin
      if (written_list.size() < 3 || $urandom_range(99) < 35) begin
        w = noise_word();
        w.action = tnt_pkg::ACT_VERTEX;
        // reuse a small pool often so corners get rewritten
        if ($urandom_range(1)) w.vertex_index = 10'($urandom_range(31));
        scale = $urandom_range(2);
        if (scale == 0) begin
          w.pos_x = $signed(w.pos_x) >>> 12;
          w.pos_y = $signed(w.pos_y) >>> 12;
          w.pos_z = $signed(w.pos_z) >>> 12;
          w.tex_u = $signed(w.tex_u) >>> 10;
          w.tex_v = $signed(w.tex_v) >>> 10;
        end
        push_word(w);
      end else begin
        put_triangle(written_list[$urandom_range(written_list.size() - 1)],
                     written_list[$urandom_range(written_list.size() - 1)],
                     written_list[$urandom_range(written_list.size() - 1)],
                     $urandom_range(3) != 0);
      end
    end
  endtask

  // result side: random ready, one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        sb.check_face({res_if.normal_x, res_if.normal_y, res_if.normal_z,
                       res_if.tangent_x, res_if.tangent_y, res_if.tangent_z,
                       res_if.tangent_valid, res_if.flat_triangle, res_if.uv_degenerate});
      end
      if (hold_req && !held) begin
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WDOG_LIMIT) begin
        $display("** triangle_normal_tangent_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    calm     = 1'b0;
    hold_req = 1'b0;
    rst_ni   <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.action <= tnt_pkg::ACT_VERTEX;
    in_if.vertex_index <= '0;
    in_if.pos_x <= '0; in_if.pos_y <= '0; in_if.pos_z <= '0;
    in_if.tex_u <= '0; in_if.tex_v <= '0;
    in_if.corner_a <= '0; in_if.corner_b <= '0; in_if.corner_c <= '0;
    in_if.want_tangent <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tangents off at first: corners at the extremes
    put_vertex(0, -8388608, -8388608, -8388608, -32768, -32768);
    put_vertex(1, 8388607, 0, 0, 32767, 0);
    put_vertex(2, 0, 8388607, 0, 0, 32767);
    put_vertex(1023, 8388607, 8388607, 8388607, -1, -1);
    put_triangle(0, 1, 2, 1'b1);
    put_triangle(1023, 0, 1, 1'b0);
    wait_drained();

    set_uv(1'b1);
    // same texture coordinate on all corners: zero determinant
    put_vertex(4, 100, 0, 0, 500, 500);
    put_vertex(5, 0, 200, 0, 500, 500);
    put_vertex(6, 0, 0, 300, 500, 500);
    // one-step uv spread with wide positions: tangent saturates
    put_vertex(7, -8388608, 8388607, 0, 0, 0);
    put_vertex(8, 8388607, -8388608, 5, 1, 0);
    put_vertex(9, 0, 8388607, -8388608, 0, 1);
    put_triangle(0, 1, 2, 1'b1);
    put_triangle(1, 2, 1023, 1'b1);
    put_triangle(0, 0, 1, 1'b1);      // repeated corner: flat
    put_triangle(4, 5, 6, 1'b1);
    put_triangle(7, 8, 9, 1'b1);
    put_triangle(9, 8, 7, 1'b1);
    put_triangle(1023, 1023, 1023, 1'b1);
    put_triangle(4, 5, 6, 1'b0);
    wait_drained();

    random_phase(PHASE_WORDS / 2);
    hold_req = 1'b1;                  // receiver stalls while words keep coming
    random_phase(PHASE_WORDS / 2);
    wait_drained();

    set_uv(1'b0);
    calm = 1'b1;
    random_phase(PHASE_WORDS / 2);
    calm = 1'b0;
    random_phase(PHASE_WORDS / 2);
    wait_drained();

    set_uv(1'b1);
    random_phase(PHASE_WORDS);
    wait_drained();

    if (sb.mismatches == 0 && sb.pending_faces.size() == 0) begin
      $display("** triangle_normal_tangent_unit: PASSED **");
    end else begin
      $display("** triangle_normal_tangent_unit: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/tnt_pkg.sv
hw/rtl/tnt_in_if.sv
hw/rtl/tnt_out_if.sv
hw/rtl/tnt_ram.sv
hw/rtl/tnt_div.sv
hw/rtl/tnt_sqrt.sv
hw/rtl/triangle_normal_tangent_unit.sv
tb/triangle_normal_tangent_unit_tb.sv
